/* src/color_tag_rewriter_defines.svh */
// Assertion macros shared by the color tag rewriter RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef COLOR_TAG_REWRITER_DEFINES_SVH
`define COLOR_TAG_REWRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ctr_pkg.sv */
// Shared types and byte-generation functions for the color tag rewriter.
// No dependencies.
`default_nettype none

package ctr_pkg;

    localparam logic [7:0] CH_LT = 8'h3C;  // '<'
    localparam logic [7:0] CH_C  = 8'h63;  // 'c'
    localparam logic [7:0] CH_GT = 8'h3E;  // '>'
    localparam logic [7:0] CH_F  = 8'h46;  // 'F', both digits of the fixed alpha 0xFF

    typedef enum logic [1:0] {
        K_PASS = 2'd0,   // one byte through
        K_BRK  = 2'd1,   // '<' then the breaking byte
        K_LIT  = 2'd2,   // '<' 'c' R G B then the breaking byte
        K_HEX  = 2'd3    // "<c" RRGGBBFF ">"
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
    } t_job;

    function automatic logic [3:0] job_len(input t_kind kind);
        logic [3:0] len;
        unique case (kind)
            K_PASS:  len = 4'd1;
            K_BRK:   len = 4'd2;
            K_LIT:   len = 4'd6;
            K_HEX:   len = 4'd11;
            default: len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

    function automatic logic [7:0] job_byte(input t_job job, input logic [3:0] idx);
        logic [7:0] ch;
        ch = job.data;
        unique case (job.kind)
            K_PASS: begin
                ch = job.data;
            end
            K_BRK: begin
                ch = (idx == 4'd0) ? CH_LT : job.data;
            end
            K_LIT: begin
                unique case (idx)
                    4'd0:    ch = CH_LT;
                    4'd1:    ch = CH_C;
                    4'd2:    ch = job.red;
                    4'd3:    ch = job.grn;
                    4'd4:    ch = job.blu;
                    default: ch = job.data;
                endcase
            end
            K_HEX: begin
                unique case (idx)
                    4'd0:    ch = CH_LT;
                    4'd1:    ch = CH_C;
                    4'd2:    ch = hex_char(job.red[7:4]);
                    4'd3:    ch = hex_char(job.red[3:0]);
                    4'd4:    ch = hex_char(job.grn[7:4]);
                    4'd5:    ch = hex_char(job.grn[3:0]);
                    4'd6:    ch = hex_char(job.blu[7:4]);
                    4'd7:    ch = hex_char(job.blu[3:0]);
                    4'd8:    ch = CH_F;
                    4'd9:    ch = CH_F;
                    default: ch = CH_GT;
                endcase
            end
            default: ch = job.data;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* src/ctr_tag_parser.sv */
// Tag recognizer: tracks the tag phase, collects the color bytes and
// describes the output run each accepted byte causes. Uses ctr_pkg.
`default_nettype none
`include "color_tag_rewriter_defines.svh"

module ctr_tag_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_eos,
    output logic             o_emit,
    output ctr_pkg::t_job    o_job
);
    import ctr_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_LT   = 6'b000010,
        PH_C0   = 6'b000100,
        PH_C1   = 6'b001000,
        PH_C2   = 6'b010000,
        PH_GT   = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_red, r_grn, r_blu;
    logic [7:0] n_red, n_grn, n_blu;
    logic       emit;
    t_kind      kind;

    always_comb begin
        n_phase = r_phase;
        n_red   = r_red;
        n_grn   = r_grn;
        n_blu   = r_blu;
        emit    = 1'b0;
        kind    = K_PASS;
        unique case (r_phase)
            PH_LT: begin
                if (i_byte == CH_C) begin
                    n_phase = PH_C0;
                end else begin
                    emit    = 1'b1;
                    kind    = K_BRK;
                    n_phase = PH_IDLE;
                end
            end
            PH_C0: begin
                n_red   = i_byte;
                n_phase = PH_C1;
            end
            PH_C1: begin
                n_grn   = i_byte;
                n_phase = PH_C2;
            end
            PH_C2: begin
                n_blu   = i_byte;
                n_phase = PH_GT;
            end
            PH_GT: begin
                emit    = 1'b1;
                kind    = (i_byte == CH_GT) ? K_HEX : K_LIT;
                n_phase = PH_IDLE;
            end
            default: begin
                if (i_byte == CH_LT) begin
                    n_phase = PH_LT;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
        endcase
        // end of stream drops whatever tag is pending
        if (i_eos) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_red <= n_red;
            r_grn <= n_grn;
            r_blu <= n_blu;
        end
    end

    assign o_emit     = emit;
    assign o_job.kind = kind;
    assign o_job.data = i_byte;
    assign o_job.red  = r_red;
    assign o_job.grn  = r_grn;
    assign o_job.blu  = r_blu;

    `CTR_ASSERT_NXT(a_phase_hold, !i_fire, $stable(r_phase), "phase moved without a transaction")
    `CTR_ASSERT_NXT(a_eos_idle, i_fire && i_eos, r_phase == PH_IDLE,
        "phase not idle after end of stream")
    `CTR_ASSERT_IMP(a_tag_close, o_emit && (o_job.kind == K_HEX || o_job.kind == K_LIT),
        r_phase == PH_GT, "tag close outside closing phase")

endmodule

`default_nettype wire

/* src/ctr_byte_emitter.sv */
// Output side: holds one pending run and feeds its bytes, one per cycle while the
// output accepts, into the registered output stage. Uses ctr_pkg.
`default_nettype none
`include "color_tag_rewriter_defines.svh"

module ctr_byte_emitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  ctr_pkg::t_job    i_job,
    output logic             o_ready,
    output logic             o_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_byte,
    output logic             o_last
);
    import ctr_pkg::*;

    t_job       r_job;
    logic       r_jvld, n_jvld;
    logic [3:0] r_idx, n_idx;
    logic       r_ovld, n_ovld;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       out_adv;
    logic       job_last;
    logic       mv;

    assign out_adv  = !r_ovld || i_out_ready;
    assign job_last = (r_idx == (job_len(r_job.kind) - 4'd1));
    assign mv       = r_jvld && out_adv;
    // accept a new byte when no run is pending or as the pending run hands over its final byte
    assign o_ready  = !r_jvld || (out_adv && job_last);

    always_comb begin
        n_jvld = r_jvld;
        n_idx  = r_idx;
        n_ovld = r_ovld;
        if (mv) begin
            n_ovld = 1'b1;
            n_idx  = r_idx + 4'd1;
            if (job_last) begin
                n_jvld = 1'b0;
            end
        end else if (i_out_ready) begin
            n_ovld = 1'b0;
        end
        if (i_load) begin
            n_jvld = 1'b1;
            n_idx  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jvld <= 1'b0;
            r_ovld <= 1'b0;
            r_idx  <= 4'd0;
        end else begin
            r_jvld <= n_jvld;
            r_ovld <= n_ovld;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
        if (mv) begin
            r_obyte <= job_byte(r_job, r_idx);
            r_olast <= job_last;
        end
    end

    assign o_valid = r_ovld;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

    `CTR_ASSERT_IMP(a_idx_range, r_jvld, r_idx < job_len(r_job.kind), "run index past its length")
    `CTR_ASSERT_IMP(a_load_free, i_load && r_jvld, mv && job_last, "run overwritten before done")
    `CTR_ASSERT_NXT(a_last_mark, mv && job_last, r_ovld && r_olast, "final byte of run not marked")

endmodule

`default_nettype wire

/* src/color_tag_rewriter.sv */
// Color tag rewriter: a transaction's run passes the run register, then the
// registered output stage. Throughput 1 byte per cycle for plain text while the
// output accepts; a longer run holds the input until its final byte goes out.
// Synchronous active-low reset clears the tag phase and all valid flags.
// Top level; instantiates ctr_tag_parser and ctr_byte_emitter, uses ctr_pkg.
`default_nettype none

module color_tag_rewriter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast    // out_last
);
    import ctr_pkg::*;

    logic  fire;
    logic  emit;
    t_job  job;

    assign fire = s_axis_tvalid && s_axis_tready;

    ctr_tag_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (s_axis_tdata),
        .i_eos   (s_axis_tlast),
        .o_emit  (emit),
        .o_job   (job)
    );

    ctr_byte_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && emit),
        .i_job       (job),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire
